@@ rtl/core/q2e_pkg.sv @@
// Shared types, constants and table functions for the quaternion to Euler converter.
`timescale 1ns / 1ps
package q2e_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STAGES   = 29;
    localparam int SW            = 34;
    localparam int VW            = 37;
    localparam int NW            = 57;
    localparam int RW            = 58;

    localparam logic [31:0] QMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic signed [SW-1:0] ONE = 34'sd268435456;
    localparam logic [NW-1:0] ONE_SQ = 57'd1 << 56;
    localparam logic signed [15:0] HALF_PI = 16'sd16384;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic                 clamp;
    } q2e_side_t;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [RW-1:0] r;
    } q2e_sq_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          z;
        logic                 zero;
    } q2e_vec_t;

    typedef q2e_vec_t [2:0] q2e_trio_t;

    typedef struct packed {
        logic clamp;
        logic sp_pos;
    } q2e_tag_t;

    function automatic logic [31:0] atan_step(input logic [4:0] s);
        logic [31:0] v;
        case (s)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v & QMASK;
    endfunction

    // Turn a left half-plane vector by pi so the rotations only refine it
    function automatic q2e_vec_t pre_rotate(input logic signed [SW-1:0] y,
                                            input logic signed [SW-1:0] x);
        q2e_vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x[SW-1])
        begin
            v.x = -VW'(x);
            v.y = -VW'(y);
            v.z = 32'h80000000 & QMASK;
        end
        else
        begin
            v.x = VW'(x);
            v.y = VW'(y);
            v.z = 32'd0;
        end
        return v;
    endfunction

endpackage

@@ rtl/core/q2e_front.sv @@
// Front end: component products, atan2 arguments, clamp test and the square root operand.
`timescale 1ns / 1ps
module q2e_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [15:0]      quat_w,
    input  logic signed [15:0]      quat_x,
    input  logic signed [15:0]      quat_y,
    input  logic signed [15:0]      quat_z,
    output logic                    out_valid,
    output q2e_pkg::q2e_sq_t        out_sq,
    output q2e_pkg::q2e_side_t      out_side
);
    import q2e_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    q2e_side_t side2_reg, side2_next, side3_reg, side4_reg;
    logic [NW-1:0] sq3_reg, sq3_next;
    q2e_sq_t sq4_reg;
    logic signed [28:0] spn;

    always_comb
    begin
        side2_next.sr = (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
        side2_next.cr = ONE - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
        side2_next.sp = (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
        side2_next.sy = (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
        side2_next.cy = ONE - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
        side2_next.clamp = (side2_next.sp >= ONE) || (side2_next.sp <= -ONE);
    end

    // A clamped sine needs no root: feed zero
    assign spn = side2_reg.clamp ? 29'sd0 : side2_reg.sp[28:0];
    assign sq3_next = NW'(spn * spn);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg    <= quat_w * quat_x;
            yz_reg    <= quat_y * quat_z;
            xx_reg    <= quat_x * quat_x;
            yy_reg    <= quat_y * quat_y;
            wy_reg    <= quat_w * quat_y;
            zx_reg    <= quat_z * quat_x;
            wz_reg    <= quat_w * quat_z;
            xy_reg    <= quat_x * quat_y;
            zz_reg    <= quat_z * quat_z;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            sq3_reg   <= sq3_next;
            side4_reg <= side3_reg;
            sq4_reg.n <= ONE_SQ - sq3_reg;
            sq4_reg.r <= '0;
        end
    end

    assign out_valid = v4_reg;
    assign out_sq    = sq4_reg;
    assign out_side  = side4_reg;

endmodule

@@ rtl/core/q2e_sqrt_stage.sv @@
// One digit stage of the pipelined integer square root.
`timescale 1ns / 1ps
module q2e_sqrt_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [4:0]              k,
    input  logic                    in_valid,
    input  q2e_pkg::q2e_sq_t        in_sq,
    input  q2e_pkg::q2e_side_t      in_side,
    output logic                    out_valid,
    output q2e_pkg::q2e_sq_t        out_sq,
    output q2e_pkg::q2e_side_t      out_side
);
    import q2e_pkg::*;

    logic valid_reg;
    q2e_sq_t sq_reg, sq_next;
    q2e_side_t side_reg;
    logic [RW-1:0] bitv, trial;

    always_comb
    begin
        bitv  = RW'(1) << {k, 1'b0};
        trial = in_sq.r + bitv;
        if ({1'b0, in_sq.n} >= trial)
        begin
            sq_next.n = in_sq.n - trial[NW-1:0];
            sq_next.r = (in_sq.r >> 1) + bitv;
        end
        else
        begin
            sq_next.n = in_sq.n;
            sq_next.r = in_sq.r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/core/q2e_cordic_stage.sv @@
// One vectoring rotation stage, applied to the roll, pitch and yaw vectors side by side.
`timescale 1ns / 1ps
module q2e_cordic_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [4:0]              s,
    input  logic                    in_valid,
    input  q2e_pkg::q2e_trio_t      in_vec,
    input  q2e_pkg::q2e_tag_t       in_tag,
    output logic                    out_valid,
    output q2e_pkg::q2e_trio_t      out_vec,
    output q2e_pkg::q2e_tag_t       out_tag
);
    import q2e_pkg::*;

    logic valid_reg;
    q2e_trio_t vec_reg, vec_next;
    q2e_tag_t tag_reg;
    logic [31:0] step;
    logic signed [VW-1:0] dx [3];
    logic signed [VW-1:0] dy [3];

    assign step = atan_step(s);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dx[j] = $signed(in_vec[j].y) >>> s;
            dy[j] = $signed(in_vec[j].x) >>> s;
            vec_next[j].zero = in_vec[j].zero;
            if (!in_vec[j].y[VW-1])
            begin
                vec_next[j].x = in_vec[j].x + dx[j];
                vec_next[j].y = in_vec[j].y - dy[j];
                vec_next[j].z = in_vec[j].z + step;
            end
            else
            begin
                vec_next[j].x = in_vec[j].x - dx[j];
                vec_next[j].y = in_vec[j].y + dy[j];
                vec_next[j].z = in_vec[j].z - step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_tag   = tag_reg;

endmodule

@@ rtl/core/quaternion_to_euler_zyx_top.sv @@
// Top level: quaternion (Q1.14) to ZYX Euler angles, fully pipelined.
//
//   channel  | handshake            | payload
//   input    | in_valid / in_ready  | quat_w, quat_x, quat_y, quat_z
//   output   | out_valid / out_ready| roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One transaction per cycle while results are taken. Stages: 4 front-end stages
// (products, sums, square, operand), 29 square-root digit stages, 1 pre-rotation
// stage, 16 rotation stages and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline holds when the output register is full and not taken,
// so in_ready drops for exactly those cycles.
`timescale 1ns / 1ps
module quaternion_to_euler_zyx_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);
    import q2e_pkg::*;

    logic en;
    logic      sq_valid [SQRT_STAGES+1];
    q2e_sq_t   sq_pipe  [SQRT_STAGES+1];
    q2e_side_t sd_pipe  [SQRT_STAGES+1];
    logic      cv_valid [CORDIC_STAGES+1];
    q2e_trio_t cv_pipe  [CORDIC_STAGES+1];
    q2e_tag_t  tg_pipe  [CORDIC_STAGES+1];

    logic      pre_valid_reg;
    q2e_trio_t pre_vec_reg, pre_vec_next;
    q2e_tag_t  pre_tag_reg, pre_tag_next;
    logic      out_valid_reg;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [15:0] roll_next, pitch_next, yaw_next, pitch_raw;
    logic      clamp_reg;

    // Advance everything unless a finished result is waiting
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (sq_valid[0]),
        .out_sq    (sq_pipe[0]),
        .out_side  (sd_pipe[0])
    );

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_sqrt
        q2e_sqrt_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .k         (5'(SQRT_STAGES - 1 - i)),
            .in_valid  (sq_valid[i]),
            .in_sq     (sq_pipe[i]),
            .in_side   (sd_pipe[i]),
            .out_valid (sq_valid[i+1]),
            .out_sq    (sq_pipe[i+1]),
            .out_side  (sd_pipe[i+1])
        );
    end

    always_comb
    begin
        pre_vec_next[0] = pre_rotate(sd_pipe[SQRT_STAGES].sr, sd_pipe[SQRT_STAGES].cr);
        pre_vec_next[1] = pre_rotate(sd_pipe[SQRT_STAGES].sp,
                                     SW'(sq_pipe[SQRT_STAGES].r[28:0]));
        pre_vec_next[2] = pre_rotate(sd_pipe[SQRT_STAGES].sy, sd_pipe[SQRT_STAGES].cy);
        pre_tag_next.clamp  = sd_pipe[SQRT_STAGES].clamp;
        pre_tag_next.sp_pos = !sd_pipe[SQRT_STAGES].sp[SW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= sq_valid[SQRT_STAGES];
            out_valid_reg <= cv_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_vec_reg <= pre_vec_next;
            pre_tag_reg <= pre_tag_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
            yaw_reg     <= yaw_next;
            clamp_reg   <= tg_pipe[CORDIC_STAGES].clamp;
        end
    end

    assign cv_valid[0] = pre_valid_reg;
    assign cv_pipe[0]  = pre_vec_reg;
    assign tg_pipe[0]  = pre_tag_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        q2e_cordic_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .s         (5'(i % 32)),
            .in_valid  (cv_valid[i]),
            .in_vec    (cv_pipe[i]),
            .in_tag    (tg_pipe[i]),
            .out_valid (cv_valid[i+1]),
            .out_vec   (cv_pipe[i+1]),
            .out_tag   (tg_pipe[i+1])
        );
    end

    function automatic logic signed [15:0] round16(input q2e_vec_t v);
        logic [31:0] a;
        a = v.zero ? 32'd0 : v.z + 32'h00008000;
        return $signed(a[31:16]);
    endfunction

    always_comb
    begin
        roll_next = round16(cv_pipe[CORDIC_STAGES][0]);
        yaw_next  = round16(cv_pipe[CORDIC_STAGES][2]);
        pitch_raw = round16(cv_pipe[CORDIC_STAGES][1]);
        if (tg_pipe[CORDIC_STAGES].clamp)
            pitch_next = tg_pipe[CORDIC_STAGES].sp_pos ? HALF_PI : -HALF_PI;
        else if (pitch_raw > HALF_PI)
            pitch_next = HALF_PI;
        else if (pitch_raw < -HALF_PI)
            pitch_next = -HALF_PI;
        else
            pitch_next = pitch_raw;
    end

    assign out_valid     = out_valid_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_clamped = clamp_reg;

endmodule

@@ tb/sv/quaternion_to_euler_zyx_top_tb.sv @@
// Testbench for the quaternion to ZYX Euler angle converter, with a bit-exact angle predictor.
`timescale 1ns / 1ps
module quaternion_to_euler_zyx_top_tb;
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;

    euler_t angles_due[$];
    int     fail_count;
    int     quiet_cycles;
    bit     sender_gaps;
    bit     receiver_gaps;
    int     hold_off;

    localparam int WATCHDOG = 20000;

    quaternion_to_euler_zyx_top dut (.*);

    always #6 clk = ~clk;

    function automatic logic [31:0] arctan_entry(input int s);
        logic [31:0] t [32] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return t[s % 32] & QMASK;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring rotation, result as a 32-bit binary angle
    function automatic logic [31:0] vector_angle(input longint sy, input longint sx);
        logic [31:0] ang;
        longint      dx;
        longint      dy;
        ang = 0;
        if (sx == 0 && sy == 0)
            return 0;
        if (sx < 0)
        begin
            sx = -sx;
            sy = -sy;
            ang = 32'h80000000 & QMASK;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = sy >>> (i % 32);
            dy = sx >>> (i % 32);
            if (sy >= 0)
            begin
                sx = sx + dx;
                sy = sy - dy;
                ang = ang + arctan_entry(i);
            end
            else
            begin
                sx = sx - dx;
                sy = sy + dy;
                ang = ang - arctan_entry(i);
            end
        end
        return ang;
    endfunction

    function automatic logic signed [15:0] round_angle(input logic [31:0] a);
        logic [31:0] r;
        r = a + 32'h8000;
        return r[31:16];
    endfunction

    function automatic euler_t euler_of(input logic signed [15:0] qw, qx, qy, qz);
        longint w, x, y, z, sr, cr, sp, sy, cy, one, c;
        int     p;
        euler_t e;
        one = longint'(1) << 28;
        w = qw; x = qx; y = qy; z = qz;
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        e.clamped = 0;
        if (sp >= one || sp <= -one)
        begin
            p = (sp > 0) ? 16384 : -16384;
            e.clamped = 1;
        end
        else
        begin
            c = longint'(int_sqrt(longint'(one * one - sp * sp)));
            p = round_angle(vector_angle(sp, c));
            if (p > 16384)
                p = 16384;
            if (p < -16384)
                p = -16384;
        end
        e.roll = round_angle(vector_angle(sr, cr));
        e.pitch = p[15:0];
        e.yaw = round_angle(vector_angle(sy, cy));
        return e;
    endfunction

    // valid stays high into the next transaction; drop it only while idling
    task automatic send_quat(input logic signed [15:0] w, x, y, z);
        while (sender_gaps && $urandom_range(99) < 29)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        angles_due.push_back(euler_of(w, x, y, z));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // roughly unit quaternion: one large component, rest random
    task automatic send_near_unit();
        logic signed [15:0] c [4];
        int k;
        int s;
        k = $urandom_range(3);
        s = $urandom_range(11000, 16384);
        for (int i = 0; i < 4; i++)
            c[i] = 16'($signed($urandom_range(2 * (16384 - s) + 4000)) - (16384 - s) - 2000);
        c[k] = $urandom_range(1) ? 16'(s) : -16'(s);
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    task automatic test_directed();
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, -16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, 0);
        send_quat(11585, 0, 11585, 0);      // pitch just below +pi/2
        send_quat(11585, 0, -11585, 0);
        send_quat(11586, 0, 11586, 0);      // beyond one
        send_quat(11585, 11585, 0, 0);
        send_quat(0, 11585, 0, 11585);      // pitch just short of -pi/2 via zx
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, -8192);
        send_quat(0, 0, 11585, 11585);      // negative yaw cosine term
        send_quat(16383, 1, -1, 1);
        send_quat(-1, -1, -1, -1);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 70)
                send_near_unit();
            else
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        test_random(150);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        quat_w = 0;
        quat_x = 0;
        quat_y = 0;
        quat_z = 0;
        fail_count = 0;
        hold_off = 0;
        sender_gaps = 0;
        receiver_gaps = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        sender_gaps = 1;
        receiver_gaps = 1;
        test_random(500);
        test_backpressure();
        sender_gaps = 0;
        receiver_gaps = 0;
        test_random(300);
        sender_gaps = 1;
        receiver_gaps = 1;
        test_random(330);
        in_valid <= 0;
        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("quaternion_to_euler_zyx_top_tb: PASS");
        else
            $display("quaternion_to_euler_zyx_top_tb: FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold when requested
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 0;
            end
            else
                out_ready <= !(receiver_gaps && $urandom_range(99) < 29);
        end
    end

    always @(posedge clk)
    begin
        euler_t exp_e;
        if (out_valid && out_ready)
        begin
            if (angles_due.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_e = angles_due.pop_front();
                if (roll_angle !== exp_e.roll)
                begin
                    $error("roll_angle: expected %0d, got %0d", exp_e.roll, roll_angle);
                    fail_count++;
                end
                if (pitch_angle !== exp_e.pitch)
                begin
                    $error("pitch_angle: expected %0d, got %0d", exp_e.pitch, pitch_angle);
                    fail_count++;
                end
                if (yaw_angle !== exp_e.yaw)
                begin
                    $error("yaw_angle: expected %0d, got %0d", exp_e.yaw, yaw_angle);
                    fail_count++;
                end
                if (pitch_clamped !== exp_e.clamped)
                begin
                    $error("pitch_clamped: expected %0d, got %0d", exp_e.clamped,
                           pitch_clamped);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("quaternion_to_euler_zyx_top_tb: FAIL");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

@@ quaternion_to_euler_zyx_top.f @@
rtl/core/q2e_pkg.sv
rtl/core/q2e_front.sv
rtl/core/q2e_sqrt_stage.sv
rtl/core/q2e_cordic_stage.sv
rtl/core/quaternion_to_euler_zyx_top.sv
tb/sv/quaternion_to_euler_zyx_top_tb.sv
